FILE: rtl/crc8fc_pkg.sv
// shared types, constants and the crc-8 byte update for the frame checker
package crc8fc_pkg;

   localparam logic [7:0] CRC_POLY      = 8'h07;
   localparam logic [7:0] CRC_MSB       = 8'h80;
   localparam logic [7:0] CRC_INIT      = 8'h00;

   localparam logic [7:0] RESET_CMD_START     = 8'hAA;
   localparam logic [7:0] RESET_VERDICT_START = 8'hAB;
   localparam logic [7:0] RESET_END_BYTE      = 8'h55;

   // position of the end byte for each frame kind
   localparam logic [3:0] LAST_POS_COMMAND = 4'd14;
   localparam logic [3:0] LAST_POS_VERDICT = 4'd11;

   localparam logic [3:0] SEQ_POS_FIRST    = 4'd1;
   localparam logic [3:0] SEQ_POS_LAST     = 4'd4;
   localparam logic [3:0] CMD_FIRST_LO     = 4'd5;
   localparam logic [3:0] CMD_FIRST_HI     = 4'd8;
   localparam logic [3:0] CMD_SECOND_LO    = 4'd9;
   localparam logic [3:0] CMD_SECOND_HI    = 4'd12;
   localparam logic [3:0] VER_VERDICT_POS  = 4'd5;
   localparam logic [3:0] VER_SECOND_LO    = 4'd6;
   localparam logic [3:0] VER_SECOND_HI    = 4'd9;

   typedef enum logic [1:0] {
      CSR_FRAME_KIND    = 2'd0,
      CSR_COMMAND_START = 2'd1,
      CSR_VERDICT_START = 2'd2,
      CSR_END_BYTE      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_START = 2'd1,
      STATUS_BAD_END   = 2'd2,
      STATUS_BAD_CRC   = 2'd3
   } status_type;

   typedef struct packed {
      logic       frame_kind;
      logic [7:0] command_start_byte;
      logic [7:0] verdict_start_byte;
      logic [7:0] end_byte;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] sequence_res;
      logic [31:0] first_value;
      logic [31:0] second_value;
   } result_type;

   // msb-first crc-8, no final xor
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/crc8fc_ifs.sv
// valid/ready channel interfaces for the frame checker
interface crc8fc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;
   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface crc8fc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] sequence_res;
   logic [31:0] first_value;
   logic [31:0] second_value;
   modport source (output valid, output status, output sequence_res, output first_value,
                   output second_value, input ready);
   modport sink   (input valid, input status, input sequence_res, input first_value,
                   input second_value, output ready);
endinterface

interface crc8fc_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/crc8fc_csr.sv
// configuration registers of the frame checker
module crc8fc_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [1:0]             wr_index,
   input  logic [7:0]             wr_data,
   output crc8fc_pkg::cfg_type    cfg
);

   crc8fc_pkg::cfg_type cfg_ff;
   crc8fc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (crc8fc_pkg::csr_index_type'(wr_index))
            crc8fc_pkg::CSR_FRAME_KIND:    cfg_in.frame_kind         = wr_data[0];
            crc8fc_pkg::CSR_COMMAND_START: cfg_in.command_start_byte = wr_data;
            crc8fc_pkg::CSR_VERDICT_START: cfg_in.verdict_start_byte = wr_data;
            crc8fc_pkg::CSR_END_BYTE:      cfg_in.end_byte           = wr_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_kind         <= 1'b0;
         cfg_ff.command_start_byte <= crc8fc_pkg::RESET_CMD_START;
         cfg_ff.verdict_start_byte <= crc8fc_pkg::RESET_VERDICT_START;
         cfg_ff.end_byte           <= crc8fc_pkg::RESET_END_BYTE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/crc8fc_parse.sv
// frame state, crc update and field capture for one byte per cycle while take is high
module crc8fc_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [7:0]               data_byte,
   input  logic                     frame_start,
   input  crc8fc_pkg::cfg_type      cfg,
   output logic                     hit,
   output crc8fc_pkg::result_type   result
);

   logic [3:0]  pos_ff, pos_in;
   logic        active_ff, active_in;
   logic [7:0]  crc_ff, crc_in;
   logic        start_good_ff, start_good_in;
   logic        crc_good_ff, crc_good_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] first_ff, first_in;
   logic [31:0] second_ff, second_in;

   logic [3:0]  last_pos;
   logic [3:0]  crc_pos;
   logic [1:0]  lane_odd;
   logic [1:0]  lane_even;
   crc8fc_pkg::status_type status;

   always_comb begin
      last_pos  = cfg.frame_kind ? crc8fc_pkg::LAST_POS_VERDICT : crc8fc_pkg::LAST_POS_COMMAND;
      crc_pos   = last_pos - 4'd1;
      // byte lane within a word: words starting at odd or even positions
      lane_odd  = pos_ff[1:0] - 2'd1;
      lane_even = pos_ff[1:0] - 2'd2;

      if (!start_good_ff) begin
         status = crc8fc_pkg::STATUS_BAD_START;
      end else if (data_byte != cfg.end_byte) begin
         status = crc8fc_pkg::STATUS_BAD_END;
      end else if (!crc_good_ff) begin
         status = crc8fc_pkg::STATUS_BAD_CRC;
      end else begin
         status = crc8fc_pkg::STATUS_OK;
      end

      result.status = status;
      if (status == crc8fc_pkg::STATUS_OK) begin
         result.sequence_res = seq_ff;
         result.first_value  = first_ff;
         result.second_value = second_ff;
      end else begin
         result.sequence_res = 32'h0;
         result.first_value  = 32'h0;
         result.second_value = 32'h0;
      end

      hit           = 1'b0;
      pos_in        = pos_ff;
      active_in     = active_ff;
      crc_in        = crc_ff;
      start_good_in = start_good_ff;
      crc_good_in   = crc_good_ff;
      seq_in        = seq_ff;
      first_in      = first_ff;
      second_in     = second_ff;

      if (frame_start) begin
         active_in     = 1'b1;
         crc_in        = crc8fc_pkg::CRC_INIT;
         start_good_in = data_byte == (cfg.frame_kind ? cfg.verdict_start_byte
                                                      : cfg.command_start_byte);
         crc_good_in   = 1'b0;
         seq_in        = 32'h0;
         first_in      = 32'h0;
         second_in     = 32'h0;
         pos_in        = 4'd1;
      end else if (active_ff) begin
         if (pos_ff >= last_pos) begin
            // end byte, also when the kind changed under a longer frame
            hit       = 1'b1;
            active_in = 1'b0;
            pos_in    = 4'd0;
         end else begin
            if (pos_ff == crc_pos) begin
               crc_good_in = crc_ff == data_byte;
            end else begin
               crc_in = crc8fc_pkg::crc8_byte(crc_ff, data_byte);
               if (pos_ff >= crc8fc_pkg::SEQ_POS_FIRST && pos_ff <= crc8fc_pkg::SEQ_POS_LAST) begin
                  seq_in[{lane_odd, 3'b000} +: 8] = data_byte;
               end else if (!cfg.frame_kind) begin
                  if (pos_ff >= crc8fc_pkg::CMD_FIRST_LO && pos_ff <= crc8fc_pkg::CMD_FIRST_HI) begin
                     first_in[{lane_odd, 3'b000} +: 8] = data_byte;
                  end else if (pos_ff >= crc8fc_pkg::CMD_SECOND_LO &&
                               pos_ff <= crc8fc_pkg::CMD_SECOND_HI) begin
                     second_in[{lane_odd, 3'b000} +: 8] = data_byte;
                  end
               end else begin
                  if (pos_ff == crc8fc_pkg::VER_VERDICT_POS) begin
                     first_in = {24'h0, data_byte};
                  end else if (pos_ff >= crc8fc_pkg::VER_SECOND_LO &&
                               pos_ff <= crc8fc_pkg::VER_SECOND_HI) begin
                     second_in[{lane_even, 3'b000} +: 8] = data_byte;
                  end
               end
            end
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 4'd0;
         active_ff     <= 1'b0;
         crc_ff        <= crc8fc_pkg::CRC_INIT;
         start_good_ff <= 1'b0;
         crc_good_ff   <= 1'b0;
         seq_ff        <= 32'h0;
         first_ff      <= 32'h0;
         second_ff     <= 32'h0;
      end else if (take) begin
         pos_ff        <= pos_in;
         active_ff     <= active_in;
         crc_ff        <= crc_in;
         start_good_ff <= start_good_in;
         crc_good_ff   <= crc_good_in;
         seq_ff        <= seq_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
      end
   end

endmodule

FILE: rtl/crc8_frame_checker_core.sv
// Frame checker top level: takes one link byte per beat and checks CRC-8 (poly 0x07)
// command or verdict frames, giving one result beat on each frame's end byte.
// Throughput is one byte per clock while no result holds the input back; a byte is registered
// on entry, its crc update and field capture then write the parse registers, and the
// result beat is held in the output register. The output register lets the next
// byte enter while a result waits; only a second result behind a stalled one holds
// the input back.
// Configuration writes are taken at any time but must only happen while the block is
// idle.
module crc8_frame_checker_core (
   input  logic                clock,
   input  logic                reset,
   crc8fc_req_if.sink          req_bus,
   crc8fc_rsp_if.source        rsp_bus,
   crc8fc_csr_if.sink          csr_bus
);

   crc8fc_pkg::cfg_type    cfg;
   crc8fc_pkg::result_type result;
   logic                   hit;
   logic                   in_take;

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_start_ff;
   logic                   out_valid_ff, out_valid_in;
   crc8fc_pkg::result_type out_res_ff;

   assign csr_bus.ready = 1'b1;

   crc8fc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.wdata),
      .cfg      (cfg)
   );

   crc8fc_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .take        (in_take),
      .data_byte   (in_byte_ff),
      .frame_start (in_start_ff),
      .cfg         (cfg),
      .hit         (hit),
      .result      (result)
   );

   // bytes without a result never wait on the output side
   assign in_take       = in_valid_ff && (!hit || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || in_take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
      out_valid_in = out_valid_ff;
      if (in_take && hit) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff  <= req_bus.data_byte;
         in_start_ff <= req_bus.frame_start;
      end
      if (in_take && hit) begin
         out_res_ff <= result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_res_ff.status;
   assign rsp_bus.sequence_res = out_res_ff.sequence_res;
   assign rsp_bus.first_value  = out_res_ff.first_value;
   assign rsp_bus.second_value = out_res_ff.second_value;

endmodule
